// ===== hdl/ehf_pkg.sv =====
// shared constants, codes and queue entry type for the energy histogram filler
package ehf_pkg;

   // field widths
   localparam int VAL_W    = 16;
   localparam int BIN_IN_W = 10;
   localparam int SEL_W    = 2;
   localparam int COUNT_W  = 32;

   // binning set-up
   localparam int NUM_BINS           = 1000;
   localparam int ENERGY_RANGE       = 16000;
   localparam int LOSS_RANGE_TWO_DIM = 7000;

   // histogram geometry: underflow, regular bins, overflow
   localparam int ROW_LEN  = NUM_BINS + 2;
   localparam int BIN_W    = $clog2(ROW_LEN);
   localparam int DEPTH_2D = ROW_LEN * ROW_LEN;
   localparam int ADDR2_W  = $clog2(DEPTH_2D);

   // width of value * NUM_BINS
   localparam int PROD_W = VAL_W + $clog2(NUM_BINS + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // action codes
   localparam logic ACT_FILL = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // histogram select codes
   localparam logic [SEL_W-1:0] SEL_LOSS    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_ENERGY  = 2'd1;
   localparam logic [SEL_W-1:0] SEL_TWO_DIM = 2'd2;

   // classified command handed from front to back
   typedef struct packed {
      logic               action;
      logic [SEL_W-1:0]   sel;
      logic               rd_ok;
      logic [BIN_W-1:0]   addr_loss;
      logic [BIN_W-1:0]   addr_en;
      logic [ADDR2_W-1:0] addr_2d;
   } cmd_type;

endpackage

// ===== hdl/energy_histogram_filler.sv =====
// top level of the energy histogram filler: front, queue and back
//
// channel   dir  handshake              fields
// req_      in   req_valid / req_stall  action, energy_loss, energy, hist_select,
//                                       read_bin_x, read_bin_y
// rsp_      out  rsp_valid / rsp_stall  count, read_hist
//
// after reset a clearing pass walks all 1004004 words of the 2d counter memory
// and zeroes them (and the 1d ones with it); req_stall is high throughout
// the front is a four-stage pipeline (scale, reciprocal, correction, address)
// each item then passes through the back: memory read, then write or result;
// the back takes no new item until the last is written or its result is given,
// as the counter memory is read-modify-write
// a stalled result holds in its register while fills go on behind it
module energy_histogram_filler
   import ehf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [VAL_W-1:0]    req_energy_loss,
   input  logic [VAL_W-1:0]    req_energy,
   input  logic [SEL_W-1:0]    req_hist_select,
   input  logic [BIN_IN_W-1:0] req_read_bin_x,
   input  logic [BIN_IN_W-1:0] req_read_bin_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic [SEL_W-1:0]    rsp_read_hist
);

   logic    clearing;
   logic    q_full;
   logic    q_valid;
   logic    q_push;
   logic    q_pop;
   cmd_type q_entry;
   cmd_type q_head;

   // classification front
   ehf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_energy_loss (req_energy_loss),
      .req_energy      (req_energy),
      .req_hist_select (req_hist_select),
      .req_read_bin_x  (req_read_bin_x),
      .req_read_bin_y  (req_read_bin_y),
      .hold            (clearing),
      .q_full          (q_full),
      .push            (q_push),
      .entry           (q_entry)
   );

   // command queue
   ehf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (q_head)
   );

   // counter back end
   ehf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_count     (rsp_count),
      .rsp_read_hist (rsp_read_hist)
   );

endmodule

// ===== hdl/ehf_front.sv =====
// front part: accepts items, works out bins and counter addresses
module ehf_front
   import ehf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [VAL_W-1:0]    req_energy_loss,
   input  logic [VAL_W-1:0]    req_energy,
   input  logic [SEL_W-1:0]    req_hist_select,
   input  logic [BIN_IN_W-1:0] req_read_bin_x,
   input  logic [BIN_IN_W-1:0] req_read_bin_y,
   input  logic                hold,
   input  logic                q_full,
   output logic                push,
   output cmd_type             entry
);

   // reciprocals for division by the ranges
   localparam int     MUL_W   = 2 * PROD_W;
   localparam longint RECIP_E = (longint'(1) << PROD_W) / ENERGY_RANGE;
   localparam longint RECIP_Y = (longint'(1) << PROD_W) / LOSS_RANGE_TWO_DIM;

   // one correction step after the reciprocal estimate, then the shift past the underflow bin or the overflow bin
   function automatic logic [BIN_W-1:0] fix_bin(
      input logic              ovf,
      input logic [BIN_W-1:0]  q0,
      input logic [PROD_W-1:0] prod,
      input logic [PROD_W-1:0] range_v
   );
      logic [PROD_W-1:0] rem;
      logic [BIN_W-1:0]  q;
      rem = prod - PROD_W'(q0) * range_v;
      q = (rem >= range_v) ? q0 + BIN_W'(1) : q0;
      fix_bin = ovf ? BIN_W'(NUM_BINS + 1) : q + BIN_W'(1);
   endfunction

   logic adv;
   logic accept;

   // stage 1 registers
   logic                s1_valid_ff;
   logic                s1_action_ff;
   logic [SEL_W-1:0]    s1_sel_ff;
   logic [BIN_IN_W-1:0] s1_bx_ff;
   logic [BIN_IN_W-1:0] s1_by_ff;
   logic                s1_rd_ok_ff;
   logic [PROD_W-1:0]   s1_prod_loss_ff;
   logic [PROD_W-1:0]   s1_prod_en_ff;
   logic                s1_ovf_loss_ff;
   logic                s1_ovf_en_ff;
   logic                s1_ovf_y_ff;

   // stage 2 registers
   logic                s2_valid_ff;
   logic                s2_action_ff;
   logic [SEL_W-1:0]    s2_sel_ff;
   logic [BIN_IN_W-1:0] s2_bx_ff;
   logic [BIN_IN_W-1:0] s2_by_ff;
   logic                s2_rd_ok_ff;
   logic [PROD_W-1:0]   s2_prod_loss_ff;
   logic [PROD_W-1:0]   s2_prod_en_ff;
   logic                s2_ovf_loss_ff;
   logic                s2_ovf_en_ff;
   logic                s2_ovf_y_ff;
   logic [BIN_W-1:0]    s2_q_loss_ff;
   logic [BIN_W-1:0]    s2_q_en_ff;
   logic [BIN_W-1:0]    s2_q_y_ff;

   // stage 3 registers
   logic                s3_valid_ff;
   logic                s3_action_ff;
   logic [SEL_W-1:0]    s3_sel_ff;
   logic [BIN_IN_W-1:0] s3_bx_ff;
   logic [BIN_IN_W-1:0] s3_by_ff;
   logic                s3_rd_ok_ff;
   logic [BIN_W-1:0]    s3_b_loss_ff;
   logic [BIN_W-1:0]    s3_b_en_ff;
   logic [BIN_W-1:0]    s3_b_y_ff;

   // stage 4 registers, the entry offered to the queue
   logic                s4_valid_ff;
   cmd_type             s4_entry_ff;

   logic [BIN_W-1:0]    x_sel;
   logic [BIN_W-1:0]    y_sel;
   logic                rd_ok_in;

   // pipeline moves as a whole unless the last entry is blocked
   assign adv       = !s4_valid_ff || !q_full;
   assign req_stall = !adv || hold;
   assign accept    = req_valid && !req_stall;
   assign push      = s4_valid_ff && !q_full;
   assign entry     = s4_entry_ff;

   // read address check
   always_comb begin
      case (req_hist_select)
         SEL_LOSS:    rd_ok_in = 32'(req_read_bin_x) < ROW_LEN;
         SEL_ENERGY:  rd_ok_in = 32'(req_read_bin_x) < ROW_LEN;
         SEL_TWO_DIM: rd_ok_in = (32'(req_read_bin_x) < ROW_LEN)
                                 && (32'(req_read_bin_y) < ROW_LEN);
         default:     rd_ok_in = 1'b0;
      endcase
   end

   // x and y bins for the 2d address, from the read or from the fill
   always_comb begin
      if (s3_action_ff == ACT_READ) begin
         x_sel = BIN_W'(s3_bx_ff);
         y_sel = BIN_W'(s3_by_ff);
      end else begin
         x_sel = s3_b_en_ff;
         y_sel = s3_b_y_ff;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // scale by bin count and flag overflow
         s1_action_ff    <= req_action;
         s1_sel_ff       <= req_hist_select;
         s1_bx_ff        <= req_read_bin_x;
         s1_by_ff        <= req_read_bin_y;
         s1_rd_ok_ff     <= rd_ok_in;
         s1_prod_loss_ff <= PROD_W'(req_energy_loss) * PROD_W'(NUM_BINS);
         s1_prod_en_ff   <= PROD_W'(req_energy) * PROD_W'(NUM_BINS);
         s1_ovf_loss_ff  <= req_energy_loss >= VAL_W'(ENERGY_RANGE);
         s1_ovf_en_ff    <= req_energy >= VAL_W'(ENERGY_RANGE);
         s1_ovf_y_ff     <= req_energy_loss >= VAL_W'(LOSS_RANGE_TWO_DIM);

         // reciprocal estimates, low by at most one
         s2_action_ff    <= s1_action_ff;
         s2_sel_ff       <= s1_sel_ff;
         s2_bx_ff        <= s1_bx_ff;
         s2_by_ff        <= s1_by_ff;
         s2_rd_ok_ff     <= s1_rd_ok_ff;
         s2_prod_loss_ff <= s1_prod_loss_ff;
         s2_prod_en_ff   <= s1_prod_en_ff;
         s2_ovf_loss_ff  <= s1_ovf_loss_ff;
         s2_ovf_en_ff    <= s1_ovf_en_ff;
         s2_ovf_y_ff     <= s1_ovf_y_ff;
         s2_q_loss_ff    <= BIN_W'((MUL_W'(s1_prod_loss_ff) * MUL_W'(RECIP_E)) >> PROD_W);
         s2_q_en_ff      <= BIN_W'((MUL_W'(s1_prod_en_ff) * MUL_W'(RECIP_E)) >> PROD_W);
         s2_q_y_ff       <= BIN_W'((MUL_W'(s1_prod_loss_ff) * MUL_W'(RECIP_Y)) >> PROD_W);

         // corrected bins
         s3_action_ff    <= s2_action_ff;
         s3_sel_ff       <= s2_sel_ff;
         s3_bx_ff        <= s2_bx_ff;
         s3_by_ff        <= s2_by_ff;
         s3_rd_ok_ff     <= s2_rd_ok_ff;
         s3_b_loss_ff    <= fix_bin(s2_ovf_loss_ff, s2_q_loss_ff, s2_prod_loss_ff,
                                    PROD_W'(ENERGY_RANGE));
         s3_b_en_ff      <= fix_bin(s2_ovf_en_ff, s2_q_en_ff, s2_prod_en_ff,
                                    PROD_W'(ENERGY_RANGE));
         s3_b_y_ff       <= fix_bin(s2_ovf_y_ff, s2_q_y_ff, s2_prod_loss_ff,
                                    PROD_W'(LOSS_RANGE_TWO_DIM));

         // counter addresses
         s4_entry_ff.action    <= s3_action_ff;
         s4_entry_ff.sel       <= s3_sel_ff;
         s4_entry_ff.rd_ok     <= s3_rd_ok_ff;
         s4_entry_ff.addr_loss <= (s3_action_ff == ACT_READ) ? BIN_W'(s3_bx_ff)
                                                             : s3_b_loss_ff;
         s4_entry_ff.addr_en   <= (s3_action_ff == ACT_READ) ? BIN_W'(s3_bx_ff)
                                                             : s3_b_en_ff;
         s4_entry_ff.addr_2d   <= ADDR2_W'(ADDR2_W'(y_sel) * ADDR2_W'(ROW_LEN)
                                           + ADDR2_W'(x_sel));
      end
   end

endmodule

// ===== hdl/ehf_queue.sv =====
// short command queue between front and back
module ehf_queue
   import ehf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type entry_in,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type head
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign valid   = fill_ff != '0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + (QPTR_W + 1)'(1);
            2'b01:   fill_ff <= fill_ff - (QPTR_W + 1)'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== hdl/ehf_back.sv =====
// back part: counter memories, clearing pass, fills and reads
module ehf_back
   import ehf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cmd_type            q_head,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COUNT_W-1:0] rsp_count,
   output logic [SEL_W-1:0]   rsp_read_hist
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPLY
   } state_type;

   // add one, holding at full scale
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (&v) ? v : v + COUNT_W'(1);
   endfunction

   logic [COUNT_W-1:0] mem_loss [ROW_LEN];
   logic [COUNT_W-1:0] mem_en   [ROW_LEN];
   logic [COUNT_W-1:0] mem_2d   [DEPTH_2D];

   state_type          state_ff;
   logic [ADDR2_W-1:0] clr_addr_ff;
   cmd_type            cur_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [SEL_W-1:0]   rsp_read_hist_ff;

   logic [COUNT_W-1:0] rd_loss_ff;
   logic [COUNT_W-1:0] rd_en_ff;
   logic [COUNT_W-1:0] rd_2d_ff;

   logic               rsp_free;
   logic               we_1d;
   logic               we_2d;
   logic [BIN_W-1:0]   wa_loss;
   logic [BIN_W-1:0]   wa_en;
   logic [ADDR2_W-1:0] wa_2d;
   logic [COUNT_W-1:0] wd_loss;
   logic [COUNT_W-1:0] wd_en;
   logic [COUNT_W-1:0] wd_2d;
   logic [COUNT_W-1:0] sel_count;

   assign clearing      = state_ff == ST_CLEAR;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_read_hist = rsp_read_hist_ff;

   // write port control and read result selection
   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && q_valid;
      rsp_free = !rsp_valid_ff || !rsp_stall;
      we_1d    = 1'b0;
      we_2d    = 1'b0;
      wa_loss  = cur_ff.addr_loss;
      wa_en    = cur_ff.addr_en;
      wa_2d    = cur_ff.addr_2d;
      wd_loss  = sat_inc(rd_loss_ff);
      wd_en    = sat_inc(rd_en_ff);
      wd_2d    = sat_inc(rd_2d_ff);
      case (state_ff)
         ST_CLEAR: begin
            we_2d   = 1'b1;
            we_1d   = 32'(clr_addr_ff) < ROW_LEN;
            wa_loss = BIN_W'(clr_addr_ff);
            wa_en   = BIN_W'(clr_addr_ff);
            wa_2d   = clr_addr_ff;
            wd_loss = '0;
            wd_en   = '0;
            wd_2d   = '0;
         end
         ST_APPLY: begin
            we_1d = cur_ff.action == ACT_FILL;
            we_2d = cur_ff.action == ACT_FILL;
         end
         default: begin
            we_1d = 1'b0;
            we_2d = 1'b0;
         end
      endcase
      case (cur_ff.sel)
         SEL_LOSS:    sel_count = rd_loss_ff;
         SEL_ENERGY:  sel_count = rd_en_ff;
         SEL_TWO_DIM: sel_count = rd_2d_ff;
         default:     sel_count = '0;
      endcase
      if (!cur_ff.rd_ok) begin
         sel_count = '0;
      end
   end

   // 1d counter memories
   always_ff @(posedge clock) begin
      if (we_1d) begin
         mem_loss[wa_loss] <= wd_loss;
         mem_en[wa_en]     <= wd_en;
      end
      if (q_pop) begin
         rd_loss_ff <= mem_loss[q_head.addr_loss];
         rd_en_ff   <= mem_en[q_head.addr_en];
      end
   end

   // 2d counter memory
   always_ff @(posedge clock) begin
      if (we_2d) begin
         mem_2d[wa_2d] <= wd_2d;
      end
      if (q_pop) begin
         rd_2d_ff <= mem_2d[q_head.addr_2d];
      end
   end

   // sequencer with result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (clr_addr_ff == ADDR2_W'(DEPTH_2D - 1)) begin
                  state_ff <= ST_IDLE;
               end
               clr_addr_ff <= clr_addr_ff + ADDR2_W'(1);
            end
            ST_IDLE: begin
               if (q_pop) begin
                  cur_ff   <= q_head;
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               if (cur_ff.action == ACT_FILL) begin
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_count_ff     <= sel_count;
                  rsp_read_hist_ff <= cur_ff.sel;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a pop is always followed by the apply step
   a_pop_apply: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_APPLY)
      else $error("pop not followed by apply");

   // no result appears during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   // a new result only comes from applying a read
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_APPLY
                              && $past(cur_ff.action) == ACT_READ)
      else $error("result not caused by a read");

   // the clearing pass never comes back once done
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> state_ff != ST_CLEAR)
      else $error("clearing pass restarted");

   // a fill never raises a result
   a_fill_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && cur_ff.action == ACT_FILL && !rsp_valid_ff)
      |=> !rsp_valid_ff)
      else $error("fill produced a result");

endmodule
